FILE: src/heading_slew_toward_point_unit_macros.svh
// Assertion helpers for the heading slew block.
// Both sample on clk and are disabled while rst_n is low.
`ifndef HEADING_SLEW_TOWARD_POINT_UNIT_MACROS_SVH
`define HEADING_SLEW_TOWARD_POINT_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HSP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/hsp_pkg.sv
package hsp_pkg;

  // Coordinate and iteration setup
  localparam int COORD_WIDTH  = 32;
  localparam int CORDIC_STEPS = 16;

  // Vector registers: difference is COORD_WIDTH+1 bits, CORDIC gain adds under two more
  localparam int VEC_W    = COORD_WIDTH + 4;
  localparam int IDX_W    = $clog2(CORDIC_STEPS);
  localparam int TAB_IW   = 5;
  localparam int ANG_W    = 26;
  localparam int ANG_FRAC = 8;
  localparam int HEAD_W   = 16;

  localparam logic signed [ANG_W-1:0] ANG_HALF  = ANG_W'(32'sh0080_0000);
  localparam logic signed [ANG_W-1:0] ANG_QUART = ANG_W'(32'sh0040_0000);
  localparam logic signed [ANG_W-1:0] ANG_ROUND = ANG_W'((1 << ANG_FRAC) - 1);

  localparam logic [HEAD_W-1:0] HALF_TURN = 16'h8000;
  localparam logic [HEAD_W-1:0] RATE_RST  = 16'd2730;

  // CORDIC vector plus angle accumulator
  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } cordic_vec_t;

  // atan(2^-i) in 1/256 binary angle units
  function automatic logic signed [ANG_W-1:0] atan_entry(input logic [TAB_IW-1:0] i);
    logic signed [ANG_W-1:0] v;
    case (i)
      5'd0:    v = ANG_W'(32'sd2097152);
      5'd1:    v = ANG_W'(32'sd1238021);
      5'd2:    v = ANG_W'(32'sd654136);
      5'd3:    v = ANG_W'(32'sd332050);
      5'd4:    v = ANG_W'(32'sd166669);
      5'd5:    v = ANG_W'(32'sd83416);
      5'd6:    v = ANG_W'(32'sd41718);
      5'd7:    v = ANG_W'(32'sd20860);
      5'd8:    v = ANG_W'(32'sd10430);
      5'd9:    v = ANG_W'(32'sd5215);
      5'd10:   v = ANG_W'(32'sd2608);
      5'd11:   v = ANG_W'(32'sd1304);
      5'd12:   v = ANG_W'(32'sd652);
      5'd13:   v = ANG_W'(32'sd326);
      5'd14:   v = ANG_W'(32'sd163);
      5'd15:   v = ANG_W'(32'sd81);
      5'd16:   v = ANG_W'(32'sd41);
      5'd17:   v = ANG_W'(32'sd20);
      5'd18:   v = ANG_W'(32'sd10);
      5'd19:   v = ANG_W'(32'sd5);
      5'd20:   v = ANG_W'(32'sd3);
      5'd21:   v = ANG_W'(32'sd1);
      5'd22:   v = ANG_W'(32'sd1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: src/hsp_cordic_step.sv
module hsp_cordic_step (
  input  hsp_pkg::cordic_vec_t     vec_in,
  input  logic [hsp_pkg::IDX_W-1:0] idx,
  output hsp_pkg::cordic_vec_t     vec_out
);

  logic signed [hsp_pkg::VEC_W-1:0] x_sh;
  logic signed [hsp_pkg::VEC_W-1:0] y_sh;
  logic signed [hsp_pkg::ANG_W-1:0] ang;
  logic [hsp_pkg::TAB_IW-1:0]       tab_idx;

  // Shifted terms round toward minus infinity
  assign x_sh    = vec_in.x >>> idx;
  assign y_sh    = vec_in.y >>> idx;
  assign tab_idx = hsp_pkg::TAB_IW'(idx);
  assign ang     = hsp_pkg::atan_entry(tab_idx);

  // Rotate toward the x axis; hold when already on it
  always_comb begin
    vec_out = vec_in;
    if (vec_in.y > 0) begin
      vec_out.x = vec_in.x + y_sh;
      vec_out.y = vec_in.y - x_sh;
      vec_out.z = vec_in.z + ang;
    end else if (vec_in.y < 0) begin
      vec_out.x = vec_in.x - y_sh;
      vec_out.y = vec_in.y + x_sh;
      vec_out.z = vec_in.z - ang;
    end
  end

endmodule

FILE: src/heading_slew_toward_point_unit.sv
// Each item passes from input transfer through a pre-rotation state, CORDIC_STEPS rotation
// steps through the shared step unit, then the turn and finish states before out_valid.
// One item is processed at a time; in_stall is high while busy, and a finished result
// waits in the output register without blocking intake.
// Reset (synchronous, rst_n low): heading 0, turn_rate 2730, no result pending.
`include "heading_slew_toward_point_unit_macros.svh"

module heading_slew_toward_point_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_self_x,
  input  logic [31:0] in_self_z,
  input  logic [31:0] in_target_x,
  input  logic [31:0] in_target_z,
  input  logic        in_gradual,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_new_heading,
  output logic [15:0] out_bearing,
  output logic        out_on_target
);

  localparam int CW = hsp_pkg::COORD_WIDTH;
  localparam int VW = hsp_pkg::VEC_W;
  localparam int AW = hsp_pkg::ANG_W;
  localparam int HW = hsp_pkg::HEAD_W;
  localparam int IW = hsp_pkg::IDX_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PRE  = 3'd1;
  localparam logic [2:0] S_STEP = 3'd2;
  localparam logic [2:0] S_TURN = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  localparam logic [IW-1:0] STEP_LAST = IW'(hsp_pkg::CORDIC_STEPS - 1);

  logic [2:0]    state_r, state_nxt;
  logic [IW-1:0] step_r, step_nxt;
  hsp_pkg::cordic_vec_t vec_r, vec_nxt, vec_step;
  logic          grad_r, grad_nxt;
  logic [HW-1:0] brg_r, brg_nxt;
  logic [HW-1:0] heading_r, heading_nxt;
  logic [HW-1:0] rate_r;
  logic          out_valid_r, out_valid_nxt;
  logic [HW-1:0] out_head_r, out_brg_r;
  logic          out_on_r;

  logic signed [VW-1:0] sx, sz, tx, tz;
  logic signed [AW-1:0] z_trunc;
  logic [HW-1:0]        diff;
  logic                 dir_up;
  logic [HW:0]          mag;
  logic [HW-1:0]        head_calc;
  logic                 in_xfer, fin_go;

  // Shared rotation unit
  hsp_cordic_step u_step (
    .vec_in  (vec_r),
    .idx     (step_r),
    .vec_out (vec_step)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign fin_go   = (state_r == S_FIN) && !(out_valid_r && out_stall);

  // Sign-extend the used coordinate bits
  assign sx = VW'(signed'(in_self_x[CW-1:0]));
  assign sz = VW'(signed'(in_self_z[CW-1:0]));
  assign tx = VW'(signed'(in_target_x[CW-1:0]));
  assign tz = VW'(signed'(in_target_z[CW-1:0]));

  // Drop the fraction, truncating toward zero
  assign z_trunc = (vec_r.z < 0) ? (vec_r.z + hsp_pkg::ANG_ROUND) : vec_r.z;

  // Wrapped gap; exactly half a turn counts as upward only when the bearing is larger
  assign diff   = brg_r - heading_r;
  assign dir_up = !diff[HW-1] || ((diff == hsp_pkg::HALF_TURN) && (brg_r > heading_r));
  assign mag    = dir_up ? {1'b0, diff} : {1'b0, (~diff) + 1'b1};

  always_comb begin
    if (!grad_r || (mag < {1'b0, rate_r})) begin
      head_calc = brg_r;
    end else if (dir_up) begin
      head_calc = heading_r + rate_r;
    end else begin
      head_calc = heading_r - rate_r;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    vec_nxt     = vec_r;
    grad_nxt    = grad_r;
    brg_nxt     = brg_r;
    heading_nxt = heading_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          vec_nxt.x = tz - sz;
          vec_nxt.y = tx - sx;
          vec_nxt.z = '0;
          grad_nxt  = in_gradual;
          state_nxt = S_PRE;
        end
      end
      S_PRE: begin
        // Fold into the right half plane
        if (vec_r.x == 0 && vec_r.y == 0) begin
          vec_nxt.z = '0;
        end else if (vec_r.x == 0) begin
          vec_nxt.y = '0;
          if (vec_r.y > 0) begin
            vec_nxt.z = hsp_pkg::ANG_QUART;
            vec_nxt.x = vec_r.y;
          end else begin
            vec_nxt.z = -hsp_pkg::ANG_QUART;
            vec_nxt.x = -vec_r.y;
          end
        end else if (vec_r.x < 0) begin
          vec_nxt.z = (vec_r.y >= 0) ? hsp_pkg::ANG_HALF : -hsp_pkg::ANG_HALF;
          vec_nxt.x = -vec_r.x;
          vec_nxt.y = -vec_r.y;
        end
        step_nxt  = '0;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        vec_nxt  = vec_step;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_LAST) begin
          state_nxt = S_TURN;
        end
      end
      S_TURN: begin
        brg_nxt   = z_trunc[hsp_pkg::ANG_FRAC +: HW];
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (fin_go) begin
          heading_nxt = head_calc;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register: load on finish, drop after transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fin_go) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      heading_r   <= '0;
      rate_r      <= hsp_pkg::RATE_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      heading_r   <= heading_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        rate_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    vec_r  <= vec_nxt;
    grad_r <= grad_nxt;
    brg_r  <= brg_nxt;
    if (fin_go) begin
      out_head_r <= head_calc;
      out_brg_r  <= brg_r;
      out_on_r   <= (head_calc == brg_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_new_heading = out_head_r;
  assign out_bearing     = out_brg_r;
  assign out_on_target   = out_on_r;

  `HSP_ASSERT_NEXT(a_fin_loads, fin_go, out_valid && (out_on_target == (out_new_heading == out_bearing)), "finished result not loaded consistently")
  `HSP_ASSERT_NEXT(a_snap, fin_go && !grad_r, out_new_heading == out_bearing, "snap item did not land on bearing")
  `HSP_ASSERT_NEXT(a_last_step, (state_r == S_STEP) && (step_r == STEP_LAST), state_r == S_TURN, "rotation did not end after last step")
  `HSP_ASSERT_SAME(a_busy, (state_r == S_STEP) || (state_r == S_TURN), in_stall && (heading_r == $past(heading_r)), "heading moved or intake open mid-item")

endmodule

FILE: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STUCK_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 24;

  typedef struct {
    logic [31:0] sx;
    logic [31:0] sz;
    logic [31:0] tx;
    logic [31:0] tz;
    logic        grad;
  } point_item_t;

  typedef struct {
    logic [15:0] head;
    logic [15:0] brg;
    logic        on_tgt;
  } heading_res_t;

  // atan(2^-i) in 1/256 binary angle units
  localparam longint ATAN_LUT [24] = '{
    2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
    10430, 5215, 2608, 1304, 652, 326, 163, 81,
    41, 20, 10, 5, 3, 1, 1, 0
  };

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_self_x = '0;
  logic [31:0] in_self_z = '0;
  logic [31:0] in_target_x = '0;
  logic [31:0] in_target_z = '0;
  logic        in_gradual = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_new_heading;
  logic [15:0] out_bearing;
  logic        out_on_target;

  point_item_t  pending_points[$];
  heading_res_t exp_headings[$];
  point_item_t  cur_item;
  heading_res_t want;

  logic [15:0] head_q = '0;
  logic [15:0] rate_q = hsp_pkg::RATE_RST;

  int items_queued = 0;
  int items_taken = 0;
  int results_seen = 0;
  int errors = 0;
  int rate_writes = 0;
  int stuck_cycles = 0;
  int gap_left = 0;
  int stall_left = 0;
  int idle_pct = 20;
  bit quiet = 1'b0;

  heading_slew_toward_point_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_self_x       (in_self_x),
    .in_self_z       (in_self_z),
    .in_target_x     (in_target_x),
    .in_target_z     (in_target_z),
    .in_gradual      (in_gradual),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_new_heading (out_new_heading),
    .out_bearing     (out_bearing),
    .out_on_target   (out_on_target)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Vectoring CORDIC bearing of (dx, dz), 0 = +Z, quarter turn = +X
  function automatic logic [15:0] bearing_toward(input longint dx, input longint dz);
    longint vx;
    longint vy;
    longint acc;
    longint t;
    int i;
    vx = dz;
    vy = dx;
    acc = 0;
    if (vx == 0 && vy == 0) return 16'h0000;
    if (vx < 0) begin
      acc = (vy >= 0) ? 64'sh80_0000 : -64'sh80_0000;
      vx = -vx;
      vy = -vy;
    end
    if (vx == 0) begin
      if (vy > 0) begin
        acc += 64'sh40_0000;
        vx = vy;
      end else begin
        acc -= 64'sh40_0000;
        vx = -vy;
      end
      vy = 0;
    end
    for (i = 0; i < hsp_pkg::CORDIC_STEPS && i < 24; i++) begin
      if (vy > 0) begin
        t = vx + (vy >>> i);
        vy = vy - (vx >>> i);
        vx = t;
        acc += ATAN_LUT[i];
      end else if (vy < 0) begin
        t = vx - (vy >>> i);
        vy = vy + (vx >>> i);
        vx = t;
        acc -= ATAN_LUT[i];
      end
    end
    return 16'(acc / 256);
  endfunction

  // Advance the heading for one transfer and queue the result it must produce
  function automatic void predict_slew(input point_item_t it);
    longint dx;
    longint dz;
    logic [15:0] brg;
    int gap;
    int mag;
    heading_res_t r;
    dx = longint'($signed(it.tx[hsp_pkg::COORD_WIDTH-1:0]))
       - longint'($signed(it.sx[hsp_pkg::COORD_WIDTH-1:0]));
    dz = longint'($signed(it.tz[hsp_pkg::COORD_WIDTH-1:0]))
       - longint'($signed(it.sz[hsp_pkg::COORD_WIDTH-1:0]));
    brg = bearing_toward(dx, dz);
    if (!it.grad) begin
      head_q = brg;
    end else begin
      gap = int'(brg) - int'(head_q);
      if (gap > 32'sh8000) gap -= 32'sh10000;
      if (gap < -32'sh8000) gap += 32'sh10000;
      mag = (gap >= 0) ? gap : -gap;
      if (mag < int'(rate_q)) head_q = brg;
      else if (gap >= 0) head_q = head_q + rate_q;
      else head_q = head_q - rate_q;
    end
    r.head = head_q;
    r.brg = brg;
    r.on_tgt = (head_q == brg);
    exp_headings.push_back(r);
  endfunction

  // Driver: hold the payload while stalled, insert idle bursts between transfers
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_slew(cur_item);
        items_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (in_valid && !quiet && $urandom_range(0, 99) < idle_pct)
          gap_left = $urandom_range(1, 3);
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_points.size() > 0) begin
          cur_item = pending_points.pop_front();
          in_self_x <= cur_item.sx;
          in_self_z <= cur_item.sz;
          in_target_x <= cur_item.tx;
          in_target_z <= cur_item.tz;
          in_gradual <= cur_item.grad;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer and stall in random bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (exp_headings.size() == 0) begin
          errors++;
          $display("%0t tb: result with none pending, heading %h bearing %h on_target %b",
                   $time, out_new_heading, out_bearing, out_on_target);
        end else begin
          want = exp_headings.pop_front();
          if (out_new_heading !== want.head) begin
            errors++;
            $display("%0t tb: new_heading expected %h actual %h",
                     $time, want.head, out_new_heading);
          end
          if (out_bearing !== want.brg) begin
            errors++;
            $display("%0t tb: bearing expected %h actual %h", $time, want.brg, out_bearing);
          end
          if (out_on_target !== want.on_tgt) begin
            errors++;
            $display("%0t tb: on_target expected %b actual %b",
                     $time, want.on_tgt, out_on_target);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: count cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("%0t tb: no transfer for %0d cycles", $time, STUCK_LIMIT);
    $display("tb: done, errors");
    $finish;
  end

  task automatic queue_item(input logic [31:0] sx, input logic [31:0] sz,
                            input logic [31:0] tx, input logic [31:0] tz, input logic g);
    point_item_t it;
    it.sx = sx;
    it.sz = sz;
    it.tx = tx;
    it.tz = tz;
    it.grad = g;
    pending_points.push_back(it);
    items_queued++;
  endtask

  // Wait until every queued item is taken and every result is back, then settle
  task automatic drain_all();
    while (items_taken != items_queued || results_seen != items_taken) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_rate(input logic [15:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    rate_q = v;
    rate_writes++;
  endtask

  function automatic logic [31:0] pick_coord();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0, 1, 2: v = $urandom;
      3: v = 32'($urandom_range(0, 2000)) - 32'd1000;
      4: v = 32'($urandom_range(0, 16)) - 32'd8;
      default: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h0000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
    endcase
    return v;
  endfunction

  // Random part: mostly approach sequences with gradual turns, some noise
  task automatic fill_random(input int n);
    int cnt;
    int len;
    int k;
    logic [31:0] sx;
    logic [31:0] sz;
    logic [31:0] tx;
    logic [31:0] tz;
    cnt = 0;
    while (cnt < n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          sx = pick_coord();
          sz = pick_coord();
          tx = pick_coord();
          tz = pick_coord();
          len = $urandom_range(3, 12);
          for (k = 0; k < len; k++) begin
            sx = sx + 32'($urandom_range(0, 20)) - 32'd10;
            sz = sz + 32'($urandom_range(0, 20)) - 32'd10;
            queue_item(sx, sz, tx, tz, $urandom_range(0, 7) != 0);
          end
          cnt += len;
        end
        7: begin
          queue_item($urandom, $urandom, $urandom, $urandom, 1'($urandom));
          cnt++;
        end
        8: begin
          sx = pick_coord();
          sz = pick_coord();
          case ($urandom_range(0, 2))
            0: queue_item(sx, sz, sx, pick_coord(), 1'($urandom));
            1: queue_item(sx, sz, pick_coord(), sz, 1'($urandom));
            default: queue_item(sx, sz, sx, sz, 1'($urandom));
          endcase
          cnt++;
        end
        default: begin
          queue_item(32'($urandom_range(0, 200)) - 32'd100, 32'($urandom_range(0, 200)) - 32'd100,
                     32'($urandom_range(0, 200)) - 32'd100, 32'($urandom_range(0, 200)) - 32'd100,
                     1'($urandom));
          cnt++;
        end
      endcase
    end
  endtask

  initial begin
    int ph;
    logic [15:0] r;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset turn rate: axes, zero gap, coordinate extremes, half-turn gap
    queue_item(32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
    queue_item(32'd0, 32'd0, 32'd0, 32'd100, 1'b0);
    queue_item(32'd0, 32'd0, 32'd100, 32'd0, 1'b0);
    queue_item(32'd0, 32'd0, 32'd0, -32'sd100, 1'b0);
    queue_item(32'd0, 32'd0, -32'sd100, 32'd0, 1'b0);
    queue_item(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    queue_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b1);
    queue_item(-32'sd5, 32'd7, -32'sd5, 32'd7, 1'b1);
    queue_item(32'd0, 32'd0, 32'd0, 32'd50, 1'b0);
    repeat (4) queue_item(32'd0, 32'd0, 32'd0, -32'sd50, 1'b1);
    queue_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b1);
    queue_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    queue_item(32'd0, 32'd0, -32'sd3, -32'sd3, 1'b1);
    queue_item(32'd0, 32'd0, 32'h7FFF_FFFF, 32'd0, 1'b0);
    drain_all();

    // Zero rate: gradual items hold the heading
    write_rate(16'h0000);
    queue_item(32'd0, 32'd0, 32'd10, 32'd0, 1'b0);
    queue_item(32'd0, 32'd0, 32'd0, 32'd10, 1'b1);
    queue_item(32'd0, 32'd0, 32'd0, 32'd10, 1'b1);
    queue_item(32'd0, 32'd0, 32'd10, 32'd0, 1'b1);
    drain_all();

    // Rate above a half turn: gradual items always snap
    write_rate(16'hFFFF);
    queue_item(32'd0, 32'd0, -32'sd7, 32'd3, 1'b1);
    queue_item(32'd0, 32'd0, 32'd9, -32'sd4, 1'b1);
    drain_all();

    // Full half-turn rate with a half-turn gap
    write_rate(16'h8000);
    queue_item(32'd0, 32'd0, 32'd0, 32'd20, 1'b0);
    queue_item(32'd0, 32'd0, 32'd0, -32'sd20, 1'b1);
    drain_all();

    // Random phases over several turn rates, the last one without idling
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: r = 16'd1;
        1: r = 16'h8000;
        2: r = 16'd0;
        5: r = hsp_pkg::RATE_RST;
        default: r = 16'($urandom_range(0, 32768));
      endcase
      write_rate(r);
      idle_pct = (ph == 3) ? 45 : 20;
      quiet = (ph == 5);
      fill_random(215);
      drain_all();
    end

    $display("tb: %0d items sent, %0d results checked", items_taken, results_seen);
    $display("tb: %0d turn-rate writes incl. zero, half turn and full 16-bit", rate_writes);
    if (errors == 0 && exp_headings.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/hsp_pkg.sv
src/hsp_cordic_step.sv
src/heading_slew_toward_point_unit.sv
tb/tb.sv
